// File: hdl/i2cseq_pkg.sv
// Shared types, codes and result builders for the I2C EEPROM transaction sequencer.
// Used by the step logic, the result queue, the top level and the testbench.
// No dependencies.
package i2cseq_pkg;

  localparam int PAGE_BYTES_DEFAULT = 64;
  localparam int MAX_RESULTS        = 3;
  localparam int QUEUE_DEPTH        = 8;
  localparam int RECIP_SHIFT        = 24;

  typedef enum logic [1:0] {
    ACT_COMMAND  = 2'd0,
    ACT_DATA     = 2'd1,
    ACT_RESPONSE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    OP_BYTE_WRITE = 3'd0,
    OP_BYTE_READ  = 3'd1,
    OP_PAGE_WRITE = 3'd2,
    OP_PAGE_READ  = 3'd3,
    OP_WORD_READ  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    BUS_START     = 3'd0,
    BUS_RESTART   = 3'd1,
    BUS_SEND      = 3'd2,
    BUS_RECV_ACK  = 3'd3,
    BUS_RECV_NACK = 3'd4,
    BUS_STOP      = 3'd5
  } bus_op_t;

  typedef enum logic [1:0] {
    KIND_BUS  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BUS_FAIL   = 2'd1,
    ST_REJECTED   = 2'd2,
    ST_UNEXPECTED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_DEV_WR   = 4'd2,
    PH_ADDR_HI  = 4'd3,
    PH_ADDR_LO  = 4'd4,
    PH_WAIT_DAT = 4'd5,
    PH_DATA     = 4'd6,
    PH_RESTART  = 4'd7,
    PH_DEV_RD   = 4'd8,
    PH_RECV     = 4'd9
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  operation;
    logic [6:0]  device_address;
    logic [15:0] register_address;
    logic [7:0]  length;
    logic        big_endian;
    logic [7:0]  data_byte;
    logic        nacked;
    logic        fault;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  bus_op;
    logic [7:0]  bus_byte;
    logic [15:0] read_value;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // Results produced by one transaction step, in order, with their count.
  typedef struct packed {
    logic [1:0]                    count;
    result_t [MAX_RESULTS-1:0]     res;
  } step_t;

  function automatic result_t mk_bus(input bus_op_t op, input logic [7:0] b);
    result_t r;
    r          = '0;
    r.kind     = KIND_BUS;
    r.bus_op   = op;
    r.bus_byte = b;
    return r;
  endfunction

  function automatic result_t mk_data(input logic [15:0] v);
    result_t r;
    r            = '0;
    r.kind       = KIND_DATA;
    r.read_value = v;
    return r;
  endfunction

  function automatic result_t mk_done(input status_t st);
    result_t r;
    r        = '0;
    r.kind   = KIND_DONE;
    r.status = st;
    return r;
  endfunction

endpackage

// File: hdl/i2cseq_channels.sv
// Valid/ready channel interfaces for the sequencer's input items and results.
// Depends on nothing; the payload fields follow the sequencer's item and result layouts.
interface i2cseq_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  operation;
  logic [6:0]  device_address;
  logic [15:0] register_address;
  logic [7:0]  length;
  logic        big_endian;
  logic [7:0]  data_byte;
  logic        nacked;
  logic        fault;

  modport source (
    output valid, action, operation, device_address, register_address, length,
           big_endian, data_byte, nacked, fault,
    input  ready
  );
  modport sink (
    input  valid, action, operation, device_address, register_address, length,
           big_endian, data_byte, nacked, fault,
    output ready
  );
endinterface

interface i2cseq_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  bus_op;
  logic [7:0]  bus_byte;
  logic [15:0] read_value;
  logic [1:0]  status;
  logic        last;

  modport source (
    output valid, kind, bus_op, bus_byte, read_value, status, last,
    input  ready
  );
  modport sink (
    input  valid, kind, bus_op, bus_byte, read_value, status, last,
    output ready
  );
endinterface

// File: hdl/i2cseq_step.sv
// Transaction state machine: advances one step per registered input item and
// produces up to three results. Depends on i2cseq_pkg.
module i2cseq_step
  import i2cseq_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid,
  input  item_t item,
  input  logic [16+$clog2(((2**RECIP_SHIFT)/PAGE_BYTES)+1)-RECIP_SHIFT-1:0] quot,
  output step_t step
);

  localparam int RECIP  = (2**RECIP_SHIFT) / PAGE_BYTES;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int QUOT_W = 16 + RECIP_W - RECIP_SHIFT;
  localparam logic [8:0] PAGE_W = 9'(PAGE_BYTES);

  phase_t      phase, phase_next;
  op_t         op_kind, op_kind_next;
  logic [6:0]  target_device, target_device_next;
  logic [15:0] target_register, target_register_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  first_read_byte, first_read_byte_next;
  logic        second_half, second_half_next;
  logic        word_order_big, word_order_big_next;

  // Offset of the command address within its page: the quotient estimate may be
  // one short, so a single conditional subtract finishes the remainder.
  logic [QUOT_W+7:0] quot_page;
  logic [16:0]       rem_raw;
  logic [7:0]        page_offset;

  assign quot_page   = quot * 8'(PAGE_BYTES);
  assign rem_raw     = {1'b0, item.register_address} - 17'(quot_page);
  assign page_offset = (rem_raw >= 17'(PAGE_BYTES)) ? 8'(rem_raw - 17'(PAGE_BYTES))
                                                   : 8'(rem_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      op_kind         <= OP_BYTE_WRITE;
      target_device   <= '0;
      target_register <= '0;
      bytes_left      <= '0;
      first_read_byte <= '0;
      second_half     <= 1'b0;
      word_order_big  <= 1'b0;
    end else begin
      phase           <= phase_next;
      op_kind         <= op_kind_next;
      target_device   <= target_device_next;
      target_register <= target_register_next;
      bytes_left      <= bytes_left_next;
      first_read_byte <= first_read_byte_next;
      second_half     <= second_half_next;
      word_order_big  <= word_order_big_next;
    end
  end

  always_comb begin
    logic [1:0] n;
    logic [7:0] left;
    logic [8:0] page_end;
    n                    = 2'd0;
    left                 = bytes_left;
    page_end             = {1'b0, page_offset} + {1'b0, item.length};
    step                 = '0;
    phase_next           = phase;
    op_kind_next         = op_kind;
    target_device_next   = target_device;
    target_register_next = target_register;
    bytes_left_next      = bytes_left;
    first_read_byte_next = first_read_byte;
    second_half_next     = second_half;
    word_order_big_next  = word_order_big;

    if (valid) begin
      case (item.action)
        ACT_COMMAND: begin
          if (phase != PH_IDLE || item.operation > OP_WORD_READ ||
              (item.operation == OP_PAGE_READ && item.length == 8'd0) ||
              (item.operation == OP_PAGE_WRITE &&
               (item.length == 8'd0 || {1'b0, item.length} > PAGE_W ||
                page_end > PAGE_W))) begin
            step.res[n] = mk_done(ST_REJECTED);
            n = n + 2'd1;
          end else begin
            op_kind_next         = op_t'(item.operation);
            target_device_next   = item.device_address;
            target_register_next = (item.operation == OP_WORD_READ) ?
                                   {8'h00, item.register_address[7:0]} :
                                   item.register_address;
            bytes_left_next      = (item.operation == OP_PAGE_WRITE ||
                                    item.operation == OP_PAGE_READ) ? item.length : 8'd1;
            first_read_byte_next = item.data_byte;
            second_half_next     = 1'b0;
            word_order_big_next  = item.big_endian;
            step.res[n] = mk_bus(BUS_START, 8'h00);
            n = n + 2'd1;
            phase_next = PH_START;
          end
        end

        ACT_DATA: begin
          if (phase == PH_WAIT_DAT) begin
            step.res[n] = mk_bus(BUS_SEND, item.data_byte);
            n = n + 2'd1;
            phase_next = PH_DATA;
          end else begin
            step.res[n] = mk_done(ST_UNEXPECTED);
            n = n + 2'd1;
          end
        end

        ACT_RESPONSE: begin
          case (phase)
            PH_START: begin
              if (item.fault) begin
                // A start that failed never took the bus, so no stop follows.
                step.res[n] = mk_done(ST_BUS_FAIL);
                n = n + 2'd1;
                phase_next = PH_IDLE;
              end else begin
                step.res[n] = mk_bus(BUS_SEND, {target_device, 1'b0});
                n = n + 2'd1;
                phase_next = PH_DEV_WR;
              end
            end

            PH_DEV_WR, PH_ADDR_HI, PH_ADDR_LO, PH_DATA, PH_DEV_RD: begin
              if (item.fault || item.nacked) begin
                step.res[n] = mk_bus(BUS_STOP, 8'h00);
                n = n + 2'd1;
                step.res[n] = mk_done(ST_BUS_FAIL);
                n = n + 2'd1;
                phase_next = PH_IDLE;
              end else begin
                case (phase)
                  PH_DEV_WR: begin
                    step.res[n] = mk_bus(BUS_SEND, target_register[15:8]);
                    n = n + 2'd1;
                    phase_next = PH_ADDR_HI;
                  end
                  PH_ADDR_HI: begin
                    step.res[n] = mk_bus(BUS_SEND, target_register[7:0]);
                    n = n + 2'd1;
                    phase_next = PH_ADDR_LO;
                  end
                  PH_ADDR_LO: begin
                    if (op_kind == OP_BYTE_WRITE) begin
                      step.res[n] = mk_bus(BUS_SEND, first_read_byte);
                      n = n + 2'd1;
                      phase_next = PH_DATA;
                    end else if (op_kind == OP_PAGE_WRITE) begin
                      phase_next = PH_WAIT_DAT;
                    end else begin
                      step.res[n] = mk_bus(BUS_RESTART, 8'h00);
                      n = n + 2'd1;
                      phase_next = PH_RESTART;
                    end
                  end
                  PH_DATA: begin
                    left = bytes_left - 8'd1;
                    bytes_left_next = left;
                    if (left == 8'd0) begin
                      step.res[n] = mk_bus(BUS_STOP, 8'h00);
                      n = n + 2'd1;
                      step.res[n] = mk_done(ST_OK);
                      n = n + 2'd1;
                      phase_next = PH_IDLE;
                    end else begin
                      phase_next = PH_WAIT_DAT;
                    end
                  end
                  default: begin
                    step.res[n] = mk_bus((op_kind == OP_PAGE_READ && bytes_left > 8'd1) ?
                                         BUS_RECV_ACK : BUS_RECV_NACK, 8'h00);
                    n = n + 2'd1;
                    phase_next = PH_RECV;
                  end
                endcase
              end
            end

            PH_RESTART: begin
              if (item.fault) begin
                step.res[n] = mk_bus(BUS_STOP, 8'h00);
                n = n + 2'd1;
                step.res[n] = mk_done(ST_BUS_FAIL);
                n = n + 2'd1;
                phase_next = PH_IDLE;
              end else begin
                step.res[n] = mk_bus(BUS_SEND, {target_device, 1'b1});
                n = n + 2'd1;
                phase_next = PH_DEV_RD;
              end
            end

            PH_RECV: begin
              if (item.fault) begin
                step.res[n] = mk_bus(BUS_STOP, 8'h00);
                n = n + 2'd1;
                step.res[n] = mk_done(ST_BUS_FAIL);
                n = n + 2'd1;
                phase_next = PH_IDLE;
              end else if (op_kind == OP_WORD_READ) begin
                if (!second_half) begin
                  // First byte in hand: close this access and start the next
                  // address, which wraps within the low byte.
                  first_read_byte_next = item.data_byte;
                  second_half_next     = 1'b1;
                  target_register_next = {8'h00, target_register[7:0] + 8'd1};
                  step.res[n] = mk_bus(BUS_STOP, 8'h00);
                  n = n + 2'd1;
                  step.res[n] = mk_bus(BUS_START, 8'h00);
                  n = n + 2'd1;
                  phase_next = PH_START;
                end else begin
                  step.res[n] = mk_data(word_order_big ? {first_read_byte, item.data_byte}
                                                       : {item.data_byte, first_read_byte});
                  n = n + 2'd1;
                  step.res[n] = mk_bus(BUS_STOP, 8'h00);
                  n = n + 2'd1;
                  step.res[n] = mk_done(ST_OK);
                  n = n + 2'd1;
                  phase_next = PH_IDLE;
                end
              end else begin
                step.res[n] = mk_data({8'h00, item.data_byte});
                n = n + 2'd1;
                left = bytes_left - 8'd1;
                bytes_left_next = left;
                if (op_kind == OP_PAGE_READ && left != 8'd0) begin
                  step.res[n] = mk_bus((left > 8'd1) ? BUS_RECV_ACK : BUS_RECV_NACK, 8'h00);
                  n = n + 2'd1;
                  phase_next = PH_RECV;
                end else begin
                  step.res[n] = mk_bus(BUS_STOP, 8'h00);
                  n = n + 2'd1;
                  step.res[n] = mk_done(ST_OK);
                  n = n + 2'd1;
                  phase_next = PH_IDLE;
                end
              end
            end

            default: begin
              step.res[n] = mk_done(ST_UNEXPECTED);
              n = n + 2'd1;
            end
          endcase
        end

        default: begin
          step.res[n] = mk_done(ST_UNEXPECTED);
          n = n + 2'd1;
        end
      endcase
    end

    if (n != 2'd0) begin
      step.res[n - 2'd1].last = 1'b1;
    end
    step.count = n;
  end

endmodule

// File: hdl/i2cseq_result_queue.sv
// Result queue: takes up to three results per cycle from the step logic and
// hands them out one per transaction. Depends on i2cseq_pkg.
module i2cseq_result_queue
  import i2cseq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  step_t   step,
  output logic    room,
  output logic    head_valid,
  output result_t head,
  input  logic    head_taken
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign pop        = head_valid && head_taken;
  // Room for the item now in the input register plus one more just accepted.
  assign room       = (count <= CNT_W'(QUEUE_DEPTH - 2 * MAX_RESULTS));

  assign wr_ptr_next = wr_ptr + PTR_W'(step.count);
  assign rd_ptr_next = rd_ptr + PTR_W'(pop);
  assign count_next  = count + CNT_W'(step.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < step.count) begin
        entries[wr_ptr + PTR_W'(i)] <= step.res[i];
      end
    end
  end

endmodule

// File: hdl/i2c_eeprom_transaction_sequencer.sv
// Timing: an accepted item is held in the input register, its results are written from there
// into the result queue, and the first result is then offered from the queue head.
// Throughput: one item per cycle while the result queue has room; each result takes one output
// transaction, so items producing several results are paced by the result queue.
// Reset (rst, synchronous, active high) returns the sequencer to idle, empties the
// input register and the result queue, and clears all transaction state.
module i2c_eeprom_transaction_sequencer
  import i2cseq_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  i2cseq_item_if.sink            item,
  i2cseq_result_if.source        result
);

  localparam int RECIP   = (2**RECIP_SHIFT) / PAGE_BYTES;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int QUOT_W  = 16 + RECIP_W - RECIP_SHIFT;

  item_t              item_q;
  logic               valid_q;
  logic [QUOT_W-1:0]  quot_q;
  logic [15+RECIP_W:0] addr_prod;
  logic               room;
  logic               accept;
  step_t              step;
  result_t            head;

  // Page quotient estimate of the command address, by reciprocal multiply.
  assign addr_prod = item.register_address * RECIP_W'(RECIP);

  assign item.ready = room;
  assign accept     = item.valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.action           <= item.action;
      item_q.operation        <= item.operation;
      item_q.device_address   <= item.device_address;
      item_q.register_address <= item.register_address;
      item_q.length           <= item.length;
      item_q.big_endian       <= item.big_endian;
      item_q.data_byte        <= item.data_byte;
      item_q.nacked           <= item.nacked;
      item_q.fault            <= item.fault;
      quot_q                  <= addr_prod[15+RECIP_W:RECIP_SHIFT];
    end
  end

  i2cseq_step #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_step (
    .clk   (clk),
    .rst   (rst),
    .valid (valid_q),
    .item  (item_q),
    .quot  (quot_q),
    .step  (step)
  );

  i2cseq_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .room       (room),
    .head_valid (result.valid),
    .head       (head),
    .head_taken (result.ready)
  );

  assign result.kind       = head.kind;
  assign result.bus_op     = head.bus_op;
  assign result.bus_byte   = head.bus_byte;
  assign result.read_value = head.read_value;
  assign result.status     = head.status;
  assign result.last       = head.last;

endmodule

// File: tb/tb_i2c_eeprom_transaction_sequencer.sv
// Self-checking testbench for the I2C EEPROM transaction sequencer: directed corner cases,
// then randomized transactions with random idling on both channels.
// Depends on i2cseq_pkg, the channel interfaces and the sequencer top level.
module tb_i2c_eeprom_transaction_sequencer;
  import i2cseq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE         = PAGE_BYTES_DEFAULT;
  localparam int RANDOM_ITEMS = 190;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;

  // Codes the package has no name for, used to provoke the error paths.
  localparam logic [1:0] ACT_RESERVED  = 2'd3;
  localparam logic [2:0] OP_UNUSED_MIN = 3'd5;
  localparam logic [2:0] OP_UNUSED_MAX = 3'd7;

  // Tracks the sequencer's transaction state and the bus requests, data and completions
  // that each accepted transaction must produce.
  class eeprom_txn_scoreboard;
    int          page_bytes;
    phase_t      ph;
    op_t         opk;
    logic [6:0]  dev;
    logic [15:0] mem_addr;
    logic [7:0]  left;
    logic [7:0]  held;
    bit          upper_done;
    bit          big;
    result_t     step_results[$];
    result_t     awaited_results[$];
    int          errors;

    function new(int page);
      page_bytes = page;
      ph         = PH_IDLE;
      opk        = OP_BYTE_WRITE;
      dev        = '0;
      mem_addr   = '0;
      left       = '0;
      held       = '0;
      upper_done = 0;
      big        = 0;
      errors     = 0;
    endfunction

    function void add(result_t r);
      if (step_results.size() < MAX_RESULTS) step_results.push_back(r);
    endfunction

    function void add_bus(bus_op_t op, logic [7:0] b);
      result_t r;
      r          = '0;
      r.kind     = KIND_BUS;
      r.bus_op   = op;
      r.bus_byte = b;
      add(r);
    endfunction

    function void add_data(logic [15:0] v);
      result_t r;
      r            = '0;
      r.kind       = KIND_DATA;
      r.read_value = v;
      add(r);
    endfunction

    function void add_done(status_t st);
      result_t r;
      r        = '0;
      r.kind   = KIND_DONE;
      r.status = st;
      add(r);
    endfunction

    function void close_out(status_t st);
      add_bus(BUS_STOP, 8'h00);
      add_done(st);
      ph = PH_IDLE;
    endfunction

    function void ask_receive();
      if (opk == OP_PAGE_READ && left > 8'd1) add_bus(BUS_RECV_ACK, 8'h00);
      else add_bus(BUS_RECV_NACK, 8'h00);
      ph = PH_RECV;
    endfunction

    function void take_command(item_t it);
      logic [15:0] a;
      logic [7:0]  n;
      a = it.register_address;
      n = it.length;
      if (ph != PH_IDLE || it.operation > OP_WORD_READ) begin
        add_done(ST_REJECTED);
        return;
      end
      if (it.operation == OP_PAGE_READ && n == 8'd0) begin
        add_done(ST_REJECTED);
        return;
      end
      if (it.operation == OP_PAGE_WRITE &&
          (n == 8'd0 || int'(n) > page_bytes ||
           int'(a) % page_bytes + int'(n) > page_bytes)) begin
        add_done(ST_REJECTED);
        return;
      end
      opk        = op_t'(it.operation);
      dev        = it.device_address;
      mem_addr   = (opk == OP_WORD_READ) ? {8'h00, a[7:0]} : a;
      left       = (opk == OP_PAGE_WRITE || opk == OP_PAGE_READ) ? n : 8'd1;
      held       = it.data_byte;
      upper_done = 0;
      big        = it.big_endian;
      add_bus(BUS_START, 8'h00);
      ph = PH_START;
    endfunction

    function void take_response(logic [7:0] d, logic nack, logic flt);
      case (ph)
        PH_START: begin
          // A start that fails leaves the bus untouched, so no stop follows.
          if (flt) begin
            add_done(ST_BUS_FAIL);
            ph = PH_IDLE;
          end else begin
            add_bus(BUS_SEND, {dev, 1'b0});
            ph = PH_DEV_WR;
          end
        end
        PH_DEV_WR, PH_ADDR_HI, PH_ADDR_LO, PH_DATA, PH_DEV_RD: begin
          if (flt || nack) close_out(ST_BUS_FAIL);
          else begin
            case (ph)
              PH_DEV_WR: begin
                add_bus(BUS_SEND, mem_addr[15:8]);
                ph = PH_ADDR_HI;
              end
              PH_ADDR_HI: begin
                add_bus(BUS_SEND, mem_addr[7:0]);
                ph = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                if (opk == OP_BYTE_WRITE) begin
                  add_bus(BUS_SEND, held);
                  ph = PH_DATA;
                end else if (opk == OP_PAGE_WRITE) begin
                  ph = PH_WAIT_DAT;
                end else begin
                  add_bus(BUS_RESTART, 8'h00);
                  ph = PH_RESTART;
                end
              end
              PH_DATA: begin
                left = left - 8'd1;
                if (left == 8'd0) close_out(ST_OK);
                else ph = PH_WAIT_DAT;
              end
              default: ask_receive();
            endcase
          end
        end
        PH_RESTART: begin
          if (flt) close_out(ST_BUS_FAIL);
          else begin
            add_bus(BUS_SEND, {dev, 1'b1});
            ph = PH_DEV_RD;
          end
        end
        PH_RECV: begin
          if (flt) close_out(ST_BUS_FAIL);
          else if (opk == OP_WORD_READ) begin
            if (!upper_done) begin
              // First half done: the second byte comes from a fresh transfer at the
              // next 8-bit address.
              held       = d;
              upper_done = 1;
              mem_addr   = {8'h00, 8'(mem_addr[7:0] + 8'd1)};
              add_bus(BUS_STOP, 8'h00);
              add_bus(BUS_START, 8'h00);
              ph = PH_START;
            end else begin
              add_data(big ? {held, d} : {d, held});
              close_out(ST_OK);
            end
          end else begin
            add_data({8'h00, d});
            left = left - 8'd1;
            if (opk == OP_PAGE_READ && left != 8'd0) ask_receive();
            else close_out(ST_OK);
          end
        end
        default: add_done(ST_UNEXPECTED);
      endcase
    endfunction

    function void sequence_item(item_t it);
      result_t r;
      step_results.delete();
      case (it.action)
        ACT_COMMAND: take_command(it);
        ACT_DATA: begin
          if (ph == PH_WAIT_DAT) begin
            add_bus(BUS_SEND, it.data_byte);
            ph = PH_DATA;
          end else begin
            add_done(ST_UNEXPECTED);
          end
        end
        ACT_RESPONSE: take_response(it.data_byte, it.nacked, it.fault);
        default: add_done(ST_UNEXPECTED);
      endcase
      foreach (step_results[i]) begin
        r      = step_results[i];
        r.last = (i == step_results.size() - 1);
        awaited_results.push_back(r);
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void compare_output(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with none awaited: kind %0d op %0d byte %h value %h",
                 $time, got.kind, got.bus_op, got.bus_byte, got.read_value);
        $display("%0t: result with none awaited: status %0d last %b",
                 $time, got.status, got.last);
        return;
      end
      want = awaited_results.pop_front();
      check_field("kind", 16'(want.kind), 16'(got.kind));
      check_field("bus_op", 16'(want.bus_op), 16'(got.bus_op));
      check_field("bus_byte", 16'(want.bus_byte), 16'(got.bus_byte));
      check_field("read_value", want.read_value, got.read_value);
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst;

  i2cseq_item_if   item_bus ();
  i2cseq_result_if result_bus ();

  i2c_eeprom_transaction_sequencer #(
    .PAGE_BYTES(PAGE)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  eeprom_txn_scoreboard sb = new(PAGE);

  int items_sent = 0;
  int tx_run     = 0;
  bit tx_quiet   = 0;
  int rx_run     = 0;
  bit rx_quiet   = 0;
  bit hold_results = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAIL i2c_eeprom_transaction_sequencer");
    $finish;
  end

  // Idle cycles come in runs: some runs have none at all, others draw a fresh gap each time.
  function automatic int next_gap(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 30);
      quiet    = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.action           = 2'($urandom);
    it.operation        = 3'($urandom);
    it.device_address   = 7'($urandom);
    it.register_address = 16'($urandom);
    it.length           = 8'($urandom);
    it.big_endian       = 1'($urandom);
    it.data_byte        = 8'($urandom);
    it.nacked           = 1'($urandom);
    it.fault            = 1'($urandom);
    return it;
  endfunction

  function automatic item_t command_item(logic [2:0] op, logic [15:0] a, logic [7:0] n);
    item_t it;
    it                  = rand_item();
    it.action           = ACT_COMMAND;
    it.operation        = op;
    it.register_address = a;
    it.length           = n;
    return it;
  endfunction

  function automatic item_t reply_item(bit nack, bit flt);
    item_t it;
    it        = rand_item();
    it.action = ACT_RESPONSE;
    it.nacked = nack;
    it.fault  = flt;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = next_gap(tx_run, tx_quiet);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid            <= 1'b1;
    item_bus.action           <= it.action;
    item_bus.operation        <= it.operation;
    item_bus.device_address   <= it.device_address;
    item_bus.register_address <= it.register_address;
    item_bus.length           <= it.length;
    item_bus.big_endian       <= it.big_endian;
    item_bus.data_byte        <= it.data_byte;
    item_bus.nacked           <= it.nacked;
    item_bus.fault            <= it.fault;
    do @(posedge clk); while (!item_bus.ready);
    sb.sequence_item(it);
    items_sent++;
  endtask

  task automatic drain_pause();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  // An item that the sequencer must refuse in its current phase.
  task automatic send_noise();
    item_t it;
    it = rand_item();
    case ($urandom_range(0, 2))
      0: it.action = ACT_RESERVED;
      1: begin
        it.action = ACT_COMMAND;
        if (sb.ph == PH_IDLE) it.operation = 3'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
      end
      default: it.action = (sb.ph == PH_WAIT_DAT) ? ACT_RESPONSE : ACT_DATA;
    endcase
    send_item(it);
  endtask

  task automatic advance_txn();
    item_t it;
    bit    sending;
    if ($urandom_range(0, 13) == 0) begin
      send_noise();
      return;
    end
    it = rand_item();
    if (sb.ph == PH_WAIT_DAT) begin
      it.action = ACT_DATA;
    end else begin
      // A NACK only matters after a sent byte, so elsewhere it is left fully random.
      sending   = sb.ph inside {PH_DEV_WR, PH_ADDR_HI, PH_ADDR_LO, PH_DATA, PH_DEV_RD};
      it.action = ACT_RESPONSE;
      it.nacked = sending ? ($urandom_range(0, 24) == 0) : 1'($urandom);
      it.fault  = ($urandom_range(0, 29) == 0);
    end
    send_item(it);
  endtask

  task automatic run_txn(input op_t op, input bit bad_args);
    logic [15:0] a;
    int          room;
    int          n;
    a = 16'($urandom);
    n = $urandom_range(0, 255);
    if (op == OP_PAGE_WRITE) begin
      room = PAGE - int'(a) % PAGE;
      if (!bad_args) n = $urandom_range(1, (room < 4) ? room : 4);
      else begin
        case ($urandom_range(0, 2))
          0: n = 0;
          1: n = $urandom_range(PAGE + 1, 255);
          default: n = room + $urandom_range(1, 3);
        endcase
      end
    end else if (op == OP_PAGE_READ) begin
      n = bad_args ? 0 : $urandom_range(1, 5);
    end
    send_item(command_item(op, a, 8'(n)));
    while (sb.ph != PH_IDLE) advance_txn();
  endtask

  initial begin : result_side
    int stall;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_results) begin
        hold_results = 0;
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = next_gap(rx_run, rx_quiet);
        if (stall > 0) begin
          result_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got.kind       = result_bus.kind;
      got.bus_op     = result_bus.bus_op;
      got.bus_byte   = result_bus.bus_byte;
      got.read_value = result_bus.read_value;
      got.status     = result_bus.status;
      got.last       = result_bus.last;
      sb.compare_output(got);
    end
  end

  initial begin : stimulus
    item_t it;
    int    base;
    int    txn;
    op_t   op;
    rst                       <= 1'b1;
    item_bus.valid            <= 1'b0;
    item_bus.action           <= ACT_COMMAND;
    item_bus.operation        <= OP_BYTE_WRITE;
    item_bus.device_address   <= '0;
    item_bus.register_address <= '0;
    item_bus.length           <= '0;
    item_bus.big_endian       <= 1'b0;
    item_bus.data_byte        <= '0;
    item_bus.nacked           <= 1'b0;
    item_bus.fault            <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Items that make no sense while idle, then each kind of command rejected for its arguments.
    it = rand_item();
    it.action = ACT_RESERVED;
    send_item(it);
    it = rand_item();
    it.action = ACT_DATA;
    send_item(it);
    send_item(reply_item(0, 0));
    send_item(command_item(OP_UNUSED_MAX, 16'h0000, 8'd0));
    send_item(command_item(OP_PAGE_READ, 16'h0100, 8'd0));
    send_item(command_item(OP_PAGE_WRITE, 16'h0200, 8'd0));
    send_item(command_item(OP_PAGE_WRITE, 16'h0000, 8'(PAGE + 1)));
    send_item(command_item(OP_PAGE_WRITE, 16'(PAGE - 1), 8'd2));

    // Byte write with device address, register address and length at their top, and a command mid-transaction.
    it = command_item(OP_BYTE_WRITE, 16'hFFFF, 8'hFF);
    it.device_address = 7'h7F;
    it.data_byte      = 8'hA5;
    send_item(it);
    send_item(reply_item(1, 0));
    send_item(reply_item(0, 0));
    send_item(command_item(OP_BYTE_READ, 16'h0000, 8'd0));
    send_item(reply_item(0, 0));
    send_item(reply_item(0, 0));
    send_item(reply_item(0, 0));

    // Failed start, then a device that does not acknowledge its address.
    it = command_item(OP_BYTE_READ, 16'h0000, 8'd0);
    it.device_address = 7'h00;
    send_item(it);
    send_item(reply_item(0, 1));
    send_item(command_item(OP_BYTE_READ, 16'h1234, 8'd0));
    send_item(reply_item(0, 0));
    send_item(reply_item(1, 0));
    drain_pause();

    base = items_sent;
    txn  = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (txn == 12) hold_results = 1'b1;
      if (txn == 20) drain_pause();
      if ($urandom_range(0, 5) == 0) send_noise();
      op = (txn < 5) ? op_t'(txn) : op_t'($urandom_range(0, 4));
      run_txn(op, $urandom_range(0, 7) == 0);
      txn++;
    end

    item_bus.valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS i2c_eeprom_transaction_sequencer");
    end else begin
      $display("FAIL i2c_eeprom_transaction_sequencer");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/i2cseq_pkg.sv
hdl/i2cseq_channels.sv
hdl/i2cseq_step.sv
hdl/i2cseq_result_queue.sv
hdl/i2c_eeprom_transaction_sequencer.sv
tb/tb_i2c_eeprom_transaction_sequencer.sv
